FILE: rtl/oale_pkg.sv
// oale_pkg: shared types and codes for the ordered array list engine
// command and response item structs, opcode and status codes; no dependencies
`default_nettype none

package oale_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_BADPOS   = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
    status_e            status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/oale_ram.sv
// oale_ram: generic single write port, single read port ram with registered read
// no package dependencies; contents undefined until written
`default_nettype none

module oale_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/ordered_array_list_engine_unit.sv
// ordered_array_list_engine_unit: bounded ordered list in a ram, walked by a small sequencer
// uses oale_pkg (cmd_t, rsp_t, opcode and status codes) and oale_ram for the element store
//
//   channel   ports                    direction  handshake
//   command   start, busy, cmd_i       in         taken when start && !busy
//   response  done_o, rsp_o            out        one-cycle strobe, no backpressure
//
// bad or overflowing requests answer on the cycle after acceptance
// get reads one element; locate scans from the head; insert on an append shifts nothing;
// insert and delete shift elements: one ram read and one write per cycle through the single ram port pair
// busy stays high until the response is registered; the next item can be taken while done_o shows
// reset clears the length and the sequencer; the element store needs no clearing
`default_nettype none

module ordered_array_list_engine_unit #(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output      logic         busy,
  input  wire oale_pkg::cmd_t cmd_i,
  output      logic         done_o,
  output      oale_pkg::rsp_t rsp_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SHUP = 4'b0100,
    S_SHDN = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  oale_pkg::opcode_e     op_q, op_d;
  logic [WORD_BITS-1:0]  word_q, word_d;
  logic [WORD_BITS-1:0]  val_q, val_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         base_q, base_d;
  logic [AW-1:0]         ridx_q, ridx_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rvld_q, rvld_d;
  logic                  first_q, first_d;
  logic                  done_q, done_d;
  oale_pkg::rsp_t        rsp_q, rsp_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;

  logic                  accept;
  logic                  issue;
  logic [CMPW-1:0]       posx;
  logic [CMPW-1:0]       cntx;
  logic                  pos_bad;
  logic [63:0]           in_ext;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (rem_q != '0);
  assign posx   = CMPW'(cmd_i.position);
  assign cntx   = CMPW'(count_q);
  assign pos_bad = (cmd_i.position == 8'd0) || (posx > cntx);
  assign in_ext = {32'b0, cmd_i.item_value};

  oale_ram #(
    .Width (WORD_BITS),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    word_d    = word_q;
    val_d     = val_q;
    idx_d     = idx_q;
    base_d    = base_q;
    ridx_d    = idx_q;
    rem_d     = rem_q;
    count_d   = count_q;
    rvld_d    = 1'b0;
    first_d   = first_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;

    // default shape of a finishing response
    if (state_q == S_IDLE) begin
      rsp_d.result_value   = '0;
      rsp_d.found_position = '0;
      rsp_d.list_length    = 8'(count_q);
      rsp_d.status         = oale_pkg::STAT_OK;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = cmd_i.opcode;
          word_d = in_ext[WORD_BITS-1:0];
          unique case (cmd_i.opcode)
            oale_pkg::OP_GET: begin
              if (pos_bad) begin
                rsp_d.status = oale_pkg::STAT_BADPOS;
                done_d       = 1'b1;
              end else begin
                state_d = S_SHDN;
                rem_d   = CW'(1);
                idx_d   = AW'(cmd_i.position - 8'd1);
                first_d = 1'b1;
              end
            end
            oale_pkg::OP_LOCATE: begin
              state_d = S_SCAN;
              rem_d   = count_q;
              idx_d   = '0;
            end
            oale_pkg::OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                rsp_d.status = oale_pkg::STAT_OVERFLOW;
                done_d       = 1'b1;
              end else if ((cmd_i.position == 8'd0) || (posx > cntx + 1'b1)) begin
                rsp_d.status = oale_pkg::STAT_BADPOS;
                done_d       = 1'b1;
              end else begin
                state_d = S_SHUP;
                rem_d   = CW'(cntx - posx + 1'b1);
                idx_d   = AW'(count_q - 1'b1);
                base_d  = AW'(cmd_i.position - 8'd1);
              end
            end
            oale_pkg::OP_DELETE: begin
              if (pos_bad) begin
                rsp_d.status = oale_pkg::STAT_BADPOS;
                done_d       = 1'b1;
              end else begin
                state_d = S_SHDN;
                rem_d   = CW'(cntx - posx + 1'b1);
                idx_d   = AW'(cmd_i.position - 8'd1);
                first_d = 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rvld_q && (ram_rdata == word_q)) begin
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.result_value   = '0;
          rsp_d.found_position = 8'(CW'(ridx_q) + 1'b1);
          rsp_d.list_length    = 8'(count_q);
          rsp_d.status         = oale_pkg::STAT_OK;
        end else if (!issue && !rvld_q) begin
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.result_value   = '0;
          rsp_d.found_position = '0;
          rsp_d.list_length    = 8'(count_q);
          rsp_d.status         = oale_pkg::STAT_OK;
        end else if (issue) begin
          rvld_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end

      S_SHUP: begin
        // element read last cycle moves one place up
        if (rvld_q) begin
          ram_we    = 1'b1;
          ram_waddr = ridx_q + 1'b1;
          ram_wdata = ram_rdata;
        end else if (!issue) begin
          ram_we               = 1'b1;
          ram_waddr            = base_q;
          ram_wdata            = word_q;
          count_d              = count_q + 1'b1;
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.result_value   = '0;
          rsp_d.found_position = '0;
          rsp_d.list_length    = 8'(count_q + 1'b1);
          rsp_d.status         = oale_pkg::STAT_OK;
        end
        if (issue) begin
          rvld_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          idx_d  = idx_q - 1'b1;
        end
      end

      S_SHDN: begin
        // first read is the removed (or fetched) element, the rest move one place down
        if (rvld_q) begin
          if (first_q) begin
            val_d   = ram_rdata;
            first_d = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ridx_q - 1'b1;
            ram_wdata = ram_rdata;
          end
        end else if (!issue) begin
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.result_value   = 32'(64'(val_q));
          rsp_d.found_position = '0;
          rsp_d.status         = oale_pkg::STAT_OK;
          if (op_q == oale_pkg::OP_DELETE) begin
            count_d           = count_q - 1'b1;
            rsp_d.list_length = 8'(count_q - 1'b1);
          end else begin
            rsp_d.list_length = 8'(count_q);
          end
        end
        if (issue) begin
          rvld_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      rvld_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      rvld_q  <= rvld_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    word_q <= word_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    base_q <= base_d;
    ridx_q <= ridx_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length beyond store depth");

  a_read_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> busy)
    else $error("read data pending while idle");

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("store written while idle");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == oale_pkg::STAT_OVERFLOW)) |-> (count_q == CW'(DEPTH)))
    else $error("overflow reported on a list that is not full");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHDN && state_d == S_IDLE && op_q == oale_pkg::OP_DELETE)
      |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the list by one");
`endif

endmodule

`default_nettype wire
